// File: src/sde_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 / SHA-224 digest engine package
// Shared types, round constants, initial hash values and round functions.
// ----------------------------------------------------------------------------
package sde_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      SDE_IDLE,
      SDE_ROUND,
      SDE_FINAL,
      SDE_PAD,
      SDE_EMIT
   } sde_state_type;

   typedef logic [31:0] sde_word_type;

   // Register index decoded from paddr[2]
   localparam logic SDE_REG_DIGEST_MODE = 1'b0;

   // Mode codes
   localparam logic SDE_MODE_224 = 1'b0;
   localparam logic SDE_MODE_256 = 1'b1;

   // Index of the final digest word per mode
   localparam logic [2:0] SDE_LAST_224 = 3'd6;
   localparam logic [2:0] SDE_LAST_256 = 3'd7;

   // Padding marker byte and the block fill at which the length starts
   localparam logic [7:0] SDE_PAD_MARK  = 8'h80;
   localparam logic [5:0] SDE_LEN_START = 6'd56;
   localparam logic [5:0] SDE_FILL_LAST = 6'd63;
   localparam logic [5:0] SDE_ROUND_LAST = 6'd63;
   localparam logic [3:0] SDE_LEN_DONE  = 4'd8;

   localparam sde_word_type SDE_IV224 [8] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   localparam sde_word_type SDE_IV256 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam sde_word_type SDE_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic sde_word_type sde_rotr(input sde_word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic sde_word_type sde_bsig0(input sde_word_type x);
      return sde_rotr(x, 2) ^ sde_rotr(x, 13) ^ sde_rotr(x, 22);
   endfunction

   function automatic sde_word_type sde_bsig1(input sde_word_type x);
      return sde_rotr(x, 6) ^ sde_rotr(x, 11) ^ sde_rotr(x, 25);
   endfunction

   function automatic sde_word_type sde_ssig0(input sde_word_type x);
      return sde_rotr(x, 7) ^ sde_rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic sde_word_type sde_ssig1(input sde_word_type x);
      return sde_rotr(x, 17) ^ sde_rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic sde_word_type sde_ch(input sde_word_type e, input sde_word_type f,
                                           input sde_word_type g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic sde_word_type sde_maj(input sde_word_type a, input sde_word_type b,
                                            input sde_word_type c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

// File: src/sde_if.sv
// ----------------------------------------------------------------------------
// SHA-256 / SHA-224 digest engine channels
// Valid/ready channels for message byte items and digest word items.
// ----------------------------------------------------------------------------
interface sde_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
   modport sink   (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sde_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: src/sha256_digest_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 / SHA-224 digest engine
// Byte-serial hasher with built-in padding and a single shared round unit.
// ----------------------------------------------------------------------------
//  channel    dir   handshake          payload
//  req_item   in    valid/ready        msg_byte, byte_present, end_of_message
//  rsp_item   out   valid/ready        digest_word, word_index, last_word
//  apb        in    psel/penable/...   digest_mode at byte address 0
//
//  A byte item is taken only while idle; the item that fills a block adds 64
//  rounds and one chaining add on the shared round unit.
//  End of message inserts padding one byte per cycle outside compressions
//  (up to 72 bytes, one or two block compressions), then shows 7 or 8 digest words.
//  Reset is synchronous; no clearing pass.
//  A stalled digest word holds until rsp_item.ready is high.
// ----------------------------------------------------------------------------
module sha256_digest_engine
   import sde_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   sde_req_if.sink           req_item,
   sde_rsp_if.source         rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   sde_state_type state_ff, state_in;
   logic          mode_ff, mode_in;
   sde_word_type  chain_ff [8];
   sde_word_type  chain_in [8];
   sde_word_type  vars_ff [8];
   sde_word_type  vars_in [8];
   sde_word_type  win_ff [16];
   sde_word_type  win_in [16];
   logic [23:0]   acc_ff, acc_in;
   logic [5:0]    fill_ff, fill_in;
   logic [60:0]   count_ff, count_in;
   logic [5:0]    round_ff, round_in;
   logic          pad_active_ff, pad_active_in;
   logic          pad_mark_ff, pad_mark_in;
   logic [3:0]    len_cnt_ff, len_cnt_in;
   logic [2:0]    word_idx_ff, word_idx_in;

   logic          req_take;
   logic          rsp_take;
   logic          csr_write;
   logic          put_en;
   logic [7:0]    put_val;
   logic          block_done;
   logic [2:0]    last_idx;
   logic          last_out;
   logic [63:0]   len_bits;
   sde_word_type  t1;
   sde_word_type  t2;
   sde_word_type  w_new;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == SDE_REG_DIGEST_MODE);
   assign prdata    = (paddr[2] == SDE_REG_DIGEST_MODE) ? {31'd0, mode_ff} : 32'd0;

   assign req_take  = req_item.valid && req_item.ready;
   assign rsp_take  = rsp_item.valid && rsp_item.ready;
   assign last_idx  = (mode_ff == SDE_MODE_256) ? SDE_LAST_256 : SDE_LAST_224;
   assign last_out  = (word_idx_ff == last_idx);
   assign len_bits  = {count_ff, 3'b000};

   // Drive handshake and result outputs from state
   always_comb begin
      req_item.ready       = (state_ff == SDE_IDLE);
      rsp_item.valid       = (state_ff == SDE_EMIT);
      rsp_item.digest_word = chain_ff[0];
      rsp_item.word_index  = word_idx_ff;
      rsp_item.last_word   = last_out;
   end

   // Select the byte that enters the block this cycle
   always_comb begin
      put_en  = 1'b0;
      put_val = 8'd0;
      unique case (state_ff)
         SDE_IDLE: begin
            put_en  = req_take && req_item.byte_present;
            put_val = req_item.msg_byte;
         end
         SDE_PAD: begin
            put_en = 1'b1;
            priority if (!pad_mark_ff) begin
               put_val = SDE_PAD_MARK;
            end else if (fill_ff != SDE_LEN_START && len_cnt_ff == 4'd0) begin
               put_val = 8'd0;
            end else begin
               put_val = len_bits[{3'd7 - len_cnt_ff[2:0], 3'b000} +: 8];
            end
         end
         SDE_ROUND, SDE_FINAL, SDE_EMIT: begin
            put_en = 1'b0;
         end
         default: begin
            put_en = 1'b0;
         end
      endcase
   end

   assign block_done = put_en && (fill_ff == SDE_FILL_LAST);

   // Shared round unit: one compression round and one schedule word
   assign t1 = vars_ff[7] + sde_bsig1(vars_ff[4]) + sde_ch(vars_ff[4], vars_ff[5], vars_ff[6])
               + SDE_K[round_ff] + win_ff[0];
   assign t2 = sde_bsig0(vars_ff[0]) + sde_maj(vars_ff[0], vars_ff[1], vars_ff[2]);
   assign w_new = sde_ssig1(win_ff[14]) + win_ff[9] + sde_ssig0(win_ff[1]) + win_ff[0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SDE_IDLE: begin
            if (req_take) begin
               priority if (block_done) begin
                  state_in = SDE_ROUND;
               end else if (req_item.end_of_message) begin
                  state_in = SDE_PAD;
               end else begin
                  state_in = SDE_IDLE;
               end
            end
         end
         SDE_ROUND: begin
            if (round_ff == SDE_ROUND_LAST) begin
               state_in = SDE_FINAL;
            end
         end
         SDE_FINAL: begin
            priority if (!pad_active_ff) begin
               state_in = SDE_IDLE;
            end else if (len_cnt_ff == SDE_LEN_DONE) begin
               state_in = SDE_EMIT;
            end else begin
               state_in = SDE_PAD;
            end
         end
         SDE_PAD: begin
            if (block_done) begin
               state_in = SDE_ROUND;
            end
         end
         SDE_EMIT: begin
            if (rsp_take && last_out) begin
               state_in = SDE_IDLE;
            end
         end
         default: begin
            state_in = SDE_IDLE;
         end
      endcase
      if (csr_write) begin
         state_in = SDE_IDLE;
      end
   end

   // Datapath and counters
   always_comb begin
      mode_in       = mode_ff;
      chain_in      = chain_ff;
      vars_in       = vars_ff;
      win_in        = win_ff;
      acc_in        = acc_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      round_in      = round_ff;
      pad_active_in = pad_active_ff;
      pad_mark_in   = pad_mark_ff;
      len_cnt_in    = len_cnt_ff;
      word_idx_in   = word_idx_ff;

      // Absorb one byte: pack big-endian, push whole words into the window
      if (put_en) begin
         acc_in  = {acc_ff[15:0], put_val};
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'b11) begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = {acc_ff, put_val};
         end
      end

      // Load the round registers when a block completes
      if (block_done) begin
         vars_in  = chain_ff;
         round_in = 6'd0;
      end

      // Count message bytes and open padding on the final item
      if (state_ff == SDE_IDLE && req_take) begin
         if (req_item.byte_present) begin
            count_in = count_ff + 61'd1;
         end
         if (req_item.end_of_message) begin
            pad_active_in = 1'b1;
            pad_mark_in   = 1'b0;
            len_cnt_in    = 4'd0;
         end
      end

      // Advance padding phase
      if (state_ff == SDE_PAD) begin
         priority if (!pad_mark_ff) begin
            pad_mark_in = 1'b1;
         end else if (fill_ff != SDE_LEN_START && len_cnt_ff == 4'd0) begin
            pad_mark_in = 1'b1;
         end else begin
            len_cnt_in = len_cnt_ff + 4'd1;
         end
      end

      // Run one round and slide the schedule window
      if (state_ff == SDE_ROUND) begin
         for (int i = 7; i > 0; i--) begin
            vars_in[i] = vars_ff[i - 1];
         end
         vars_in[4] = vars_ff[3] + t1;
         vars_in[0] = t1 + t2;
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = w_new;
         round_in   = round_ff + 6'd1;
      end

      // Fold the round result into the chaining value
      if (state_ff == SDE_FINAL) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
         word_idx_in = 3'd0;
      end

      // Shift out digest words; restart after the last one
      if (state_ff == SDE_EMIT && rsp_take) begin
         if (last_out) begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = (mode_ff == SDE_MODE_256) ? SDE_IV256[i] : SDE_IV224[i];
            end
            count_in      = 61'd0;
            fill_in       = 6'd0;
            pad_active_in = 1'b0;
         end else begin
            for (int i = 0; i < 7; i++) begin
               chain_in[i] = chain_ff[i + 1];
            end
            chain_in[7] = chain_ff[0];
            word_idx_in = word_idx_ff + 3'd1;
         end
      end

      // Mode write aborts the message and reloads the initial values
      if (csr_write) begin
         mode_in = pwdata[0];
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = (pwdata[0] == SDE_MODE_256) ? SDE_IV256[i] : SDE_IV224[i];
         end
         count_in      = 61'd0;
         fill_in       = 6'd0;
         pad_active_in = 1'b0;
      end
   end

   // Control and chaining registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SDE_IDLE;
         mode_ff       <= SDE_MODE_256;
         chain_ff      <= SDE_IV256;
         fill_ff       <= 6'd0;
         count_ff      <= 61'd0;
         round_ff      <= 6'd0;
         pad_active_ff <= 1'b0;
         pad_mark_ff   <= 1'b0;
         len_cnt_ff    <= 4'd0;
         word_idx_ff   <= 3'd0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         chain_ff      <= chain_in;
         fill_ff       <= fill_in;
         count_ff      <= count_in;
         round_ff      <= round_in;
         pad_active_ff <= pad_active_in;
         pad_mark_ff   <= pad_mark_in;
         len_cnt_ff    <= len_cnt_in;
         word_idx_ff   <= word_idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
      win_ff  <= win_in;
      acc_ff  <= acc_in;
   end

`ifndef SYNTH
   a_ready_vs_valid: assert property (@(posedge clock) disable iff (reset)
      !(req_item.ready && rsp_item.valid))
      else $error("input ready while a digest word is shown");

   a_emit_clean_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SDE_EMIT) |-> (fill_ff == 6'd0 && pad_active_ff))
      else $error("digest shown with a partial block pending");

   a_round_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SDE_ROUND && round_ff != SDE_ROUND_LAST && !csr_write)
      |=> (state_ff == SDE_ROUND))
      else $error("compression left before the last round");

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && last_out && !csr_write)
      |=> (state_ff == SDE_IDLE && count_ff == 61'd0 && fill_ff == 6'd0))
      else $error("engine not restarted after the last digest word");
`endif

endmodule
